/* rtl/ibpu_pkg.sv */
// Shared types and constants for the indexed bitmap pixel unpacker.
package ibpu_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CFG_W       = 13;
   localparam int DIM_CODE_MAX = 8191;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // Pixel depth codes
   localparam logic [1:0] MODE_1BPP = 2'd0;
   localparam logic [1:0] MODE_4BPP = 2'd1;
   localparam logic [1:0] MODE_8BPP = 2'd2;

   localparam logic [1:0]       DEPTH_MODE_RESET = MODE_8BPP;
   localparam logic [CFG_W-1:0] DIM_RESET        = 13'd1;

   // Item opcodes
   localparam logic OPCODE_PALETTE = 1'b0;
   localparam logic OPCODE_DATA    = 1'b1;

   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 24;
   localparam int COORD_W = 12;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic              opcode;
      logic [BYTE_W-1:0] palette_index;
      logic [BYTE_W-1:0] palette_red;
      logic [BYTE_W-1:0] palette_green;
      logic [BYTE_W-1:0] palette_blue;
      logic [BYTE_W-1:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_column;
      logic [COORD_W-1:0] pixel_row;
      logic [BYTE_W-1:0]  red_out;
      logic [BYTE_W-1:0]  green_out;
      logic [BYTE_W-1:0]  blue_out;
      logic               last_of_byte;
      logic               image_done;
   } rsp_item_type;

   // Palette port command
   typedef struct packed {
      logic               wr_en;
      logic               rd_en;
      logic [BYTE_W-1:0]  addr;
      logic [COLOR_W-1:0] wdata;
   } pal_req_type;

endpackage

/* rtl/indexed_bitmap_pixel_unpacker_core.sv */
// Top level of the indexed bitmap pixel unpacker.
//
// Accepts palette writes and image-data bytes of a 1, 4 or 8 bit per pixel
// bitmap on the req_ channel and returns one rsp_ item per real pixel:
// column, row, and the red/green/blue triple looked up in a 256-entry
// palette. Pixels are unpacked most significant first; padding pixels and
// the padding bytes that round each row up to a 4-byte multiple produce no
// item. Rows count in stream order and wrap after the configured height.
// Rate: one palette access per cycle while the result queue has room; a
// palette write takes one access, a data byte one read per pixel it
// yields, and a byte holding only padding none. The rate is set
// by the single read/write port of the palette memory: every pixel needs one
// palette read. The next item is accepted in the cycle the current one
// issues its last palette access. Read data and pixel metadata are
// registered, then queued before rsp_; the 4-entry result queue absorbs
// result stalls without holding up the palette reads already issued.
// The palette powers up undefined and needs no clearing pass: entries must
// be written before any pixel refers to them. Row position counters are
// updated at acceptance, so csr_ writes must only happen while the block
// is idle. csr_ready is always high.
module indexed_bitmap_pixel_unpacker_core
   import ibpu_pkg::*;
#(
   parameter int MAX_WIDTH     = 4096,
   parameter int MAX_HEIGHT    = 4096,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   // item input
   input  logic                   req_valid,
   input  req_item_type           req_item,
   output logic                   req_stall,
   // pixel output
   output logic                   rsp_valid,
   output rsp_item_type           rsp_item,
   input  logic                   rsp_stall,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   // Effective limits: the size registers cannot exceed their 13-bit code.
   localparam int WMAX     = (MAX_WIDTH > DIM_CODE_MAX) ? DIM_CODE_MAX : MAX_WIDTH;
   localparam int HMAX     = (MAX_HEIGHT > DIM_CODE_MAX) ? DIM_CODE_MAX : MAX_HEIGHT;
   localparam int ROWB_MAX = ((WMAX + 3) / 4) * 4;
   localparam int RB_W     = $clog2(ROWB_MAX + 1);
   localparam int COL_W    = $clog2(ROWB_MAX * 8 + 1);
   localparam int ROW_W    = $clog2(HMAX + 1);
   // compare width covering counters and size registers
   localparam int CW       = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [1:0]       depth_mode_ff;
   logic [CFG_W-1:0] image_width_ff;
   logic [CFG_W-1:0] image_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_mode_ff   <= DEPTH_MODE_RESET;
         image_width_ff  <= DIM_RESET;
         image_height_ff <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEPTH_MODE:   depth_mode_ff   <= csr_wdata[1:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            default: ;        // drop writes beyond the register list
         endcase
      end
   end

   // Clamp sizes: zero reads as one, large values saturate.
   logic [CFG_W-1:0] width_eff;
   logic [CFG_W-1:0] height_eff;

   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = CFG_W'(1);
      end else if (image_width_ff > CFG_W'(WMAX)) begin
         width_eff = CFG_W'(WMAX);
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         height_eff = CFG_W'(1);
      end else if (image_height_ff > CFG_W'(HMAX)) begin
         height_eff = CFG_W'(HMAX);
      end else begin
         height_eff = image_height_ff;
      end
   end

   // Pixels per byte and padded row length in bytes.
   logic [3:0]       per_byte;
   logic [CFG_W:0]   row_bytes_raw;
   logic [CFG_W:0]   row_bytes;

   always_comb begin
      case (depth_mode_ff)
         MODE_1BPP: begin
            per_byte      = 4'd8;
            row_bytes_raw = ({1'b0, width_eff} + (CFG_W+1)'(7)) >> 3;
         end
         MODE_4BPP: begin
            per_byte      = 4'd2;
            row_bytes_raw = ({1'b0, width_eff} + (CFG_W+1)'(1)) >> 1;
         end
         default: begin   // 8 bit, and the unused code treated alike
            per_byte      = 4'd1;
            row_bytes_raw = {1'b0, width_eff};
         end
      endcase
      row_bytes = (row_bytes_raw + (CFG_W+1)'(3)) & ~(CFG_W+1)'(3);
   end

   // ------------------------------------------------------------------
   // Row position counters, advanced when a data item is accepted
   // ------------------------------------------------------------------
   logic [RB_W-1:0]  row_byte_ff, row_byte_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [ROW_W-1:0] row_now;
   logic [CW-1:0]    rb_next;
   logic [CW-1:0]    row_plus;
   logic [CW-1:0]    col_gap;
   logic             row_end;
   logic             row_last;
   logic [3:0]       n_emit;

   logic             accept;
   logic             accept_data;

   always_comb begin
      // a lowered height can leave the row counter out of range: wrap first
      row_now  = (CW'(row_ff) >= CW'(height_eff)) ? '0 : row_ff;
      row_last = (CW'(row_now) == CW'(height_eff) - CW'(1));
      rb_next  = CW'(row_byte_ff) + CW'(1);
      row_end  = (rb_next >= CW'(row_bytes));
      row_plus = CW'(row_now) + CW'(1);
      col_gap  = CW'(width_eff) - CW'(col_ff);

      // pixels of this byte that fall inside the row
      if (CW'(col_ff) >= CW'(width_eff)) begin
         n_emit = 4'd0;
      end else if (col_gap < CW'(per_byte)) begin
         n_emit = col_gap[3:0];
      end else begin
         n_emit = per_byte;
      end

      row_byte_in = row_byte_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (accept_data) begin
         if (row_end) begin
            row_byte_in = '0;
            col_in      = '0;
            row_in      = (row_plus >= CW'(height_eff)) ? '0 : ROW_W'(row_plus);
         end else begin
            row_byte_in = RB_W'(rb_next);
            col_in      = COL_W'(CW'(col_ff) + CW'(per_byte));
            row_in      = row_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_byte_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         row_byte_ff <= row_byte_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // Work register: the item that owns the palette port
   // ------------------------------------------------------------------
   logic             work_valid_ff, work_valid_in;
   req_item_type     work_item_ff;
   logic [2:0]       work_k_ff, work_k_in;
   logic [3:0]       work_n_ff;
   logic [COL_W-1:0] work_col_ff;
   logic [ROW_W-1:0] work_row_ff;
   logic             work_row_last_ff;

   logic [QUEUE_CNT_W-1:0] queue_count;
   logic                   s1_valid_ff;

   logic             room;
   logic             issue;
   logic             finish;
   logic             work_is_data;
   logic [BYTE_W-1:0] pix_idx;
   logic             pix_in_range;
   logic             wr_in_range;
   logic [CW-1:0]    pix_col;
   pal_req_type      pal_req;

   assign work_is_data = (work_item_ff.opcode == OPCODE_DATA);
   // keep a queue slot for every palette read in flight
   assign room = ((queue_count + QUEUE_CNT_W'(s1_valid_ff)) < QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pix_col = CW'(work_col_ff) + CW'(work_k_ff);

   // Select the pixel index of slot k, most significant pixel first.
   always_comb begin
      case (depth_mode_ff)
         MODE_1BPP: pix_idx = {7'd0, work_item_ff.data_byte[3'd7 - work_k_ff]};
         MODE_4BPP: pix_idx = work_k_ff[0] ? {4'd0, work_item_ff.data_byte[3:0]}
                                           : {4'd0, work_item_ff.data_byte[7:4]};
         default:   pix_idx = work_item_ff.data_byte;
      endcase
      pix_in_range = ({1'b0, pix_idx} < 9'(PALETTE_DEPTH));
      wr_in_range  = ({1'b0, work_item_ff.palette_index} < 9'(PALETTE_DEPTH));
   end

   // Drive the palette port: one access per cycle, writes and reads in order.
   always_comb begin
      pal_req = '0;
      issue   = 1'b0;
      finish  = 1'b0;
      if (work_valid_ff) begin
         if (!work_is_data) begin
            finish        = 1'b1;
            pal_req.wr_en = wr_in_range;
            pal_req.addr  = work_item_ff.palette_index;
            pal_req.wdata = {work_item_ff.palette_red,
                             work_item_ff.palette_green,
                             work_item_ff.palette_blue};
         end else if (work_n_ff == 4'd0) begin
            finish = 1'b1;   // padding only: nothing to look up
         end else if (room) begin
            issue         = 1'b1;
            pal_req.rd_en = pix_in_range;
            pal_req.addr  = pix_idx;
            finish        = ({1'b0, work_k_ff} + 4'd1 == work_n_ff);
         end
      end
   end

   assign req_stall   = work_valid_ff && !finish;
   assign accept      = req_valid && !req_stall;
   assign accept_data = accept && (req_item.opcode == OPCODE_DATA);

   always_comb begin
      work_valid_in = work_valid_ff;
      work_k_in     = work_k_ff;
      if (accept) begin
         work_valid_in = 1'b1;
         work_k_in     = '0;
      end else if (finish) begin
         work_valid_in = 1'b0;
      end else if (issue) begin
         work_k_in = work_k_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         work_k_ff     <= '0;
      end else begin
         work_valid_ff <= work_valid_in;
         work_k_ff     <= work_k_in;
      end
   end

   // Capture the item and its row position at acceptance.
   always_ff @(posedge clock) begin
      if (accept) begin
         work_item_ff     <= req_item;
         work_n_ff        <= accept_data ? n_emit : 4'd0;
         work_col_ff      <= col_ff;
         work_row_ff      <= row_now;
         work_row_last_ff <= row_last;
      end
   end

   // ------------------------------------------------------------------
   // Palette memory and read stage
   // ------------------------------------------------------------------
   logic [COLOR_W-1:0] pal_rd_data;

   ibpu_palette_ram #(
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .pal_req (pal_req),
      .rd_data (pal_rd_data)
   );

   // Pixel metadata travels alongside the palette read.
   logic               s1_in_range_ff;
   logic [COORD_W-1:0] s1_col_ff;
   logic [COORD_W-1:0] s1_row_ff;
   logic               s1_last_ff;
   logic               s1_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_in_range_ff <= pix_in_range;
         s1_col_ff      <= COORD_W'(pix_col);
         s1_row_ff      <= COORD_W'(work_row_ff);
         s1_last_ff     <= finish;
         s1_done_ff     <= work_row_last_ff && (pix_col == CW'(width_eff) - CW'(1));
      end
   end

   // Out-of-range indices read as black.
   rsp_item_type push_item;

   always_comb begin
      push_item.pixel_column = s1_col_ff;
      push_item.pixel_row    = s1_row_ff;
      push_item.red_out      = s1_in_range_ff ? pal_rd_data[23:16] : '0;
      push_item.green_out    = s1_in_range_ff ? pal_rd_data[15:8]  : '0;
      push_item.blue_out     = s1_in_range_ff ? pal_rd_data[7:0]   : '0;
      push_item.last_of_byte = s1_last_ff;
      push_item.image_done   = s1_done_ff;
   end

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   ibpu_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_item (push_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .count     (queue_count)
   );

endmodule

/* rtl/ibpu_palette_ram.sv */
// Single-port palette memory with registered read data.
module ibpu_palette_ram
   import ibpu_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic               clock,
   input  pal_req_type        pal_req,
   output logic [COLOR_W-1:0] rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [COLOR_W-1:0] mem [DEPTH];
   logic [COLOR_W-1:0] rd_data_ff;
   logic [AW-1:0]      addr;

   assign addr = pal_req.addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (pal_req.wr_en) begin
         mem[addr] <= pal_req.wdata;
      end
      if (pal_req.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ibpu_rsp_queue.sv */
// Small result queue that decouples pixel issue from the result channel.
module ibpu_rsp_queue
   import ibpu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rsp_item_type           push_item,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output rsp_item_type           rsp_item,
   output logic [QUEUE_CNT_W-1:0] count
);

   rsp_item_type entry_ff [QUEUE_DEPTH];

   logic [QUEUE_PTR_W-1:0] head_ff, head_in;
   logic [QUEUE_PTR_W-1:0] tail_ff, tail_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entry_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign count     = count_ff;

   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_item;
      end
   end

endmodule

/* rtl/ibpu_checker.sv */
// Port-level assertions for the indexed bitmap pixel unpacker, with bind.
module ibpu_checker
   import ibpu_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input rsp_item_type rsp_item,
   input logic         rsp_stall
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed or dropped");

   // The last pixel of the image is always the last pixel of its byte.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.image_done |-> rsp_item.last_of_byte)
      else $error("image_done without last_of_byte");

   // Reset empties the pipeline and frees the input.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind indexed_bitmap_pixel_unpacker_core ibpu_checker u_ibpu_checker (.*);
